// ===== hdl/wood_pkg.sv =====
package wood_pkg;

  localparam int unsigned WINDOW      = 10;
  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned SAMPLE_W    = 12;
  localparam int unsigned K_W         = 7;
  localparam int unsigned IDX_W       = 24;

  localparam logic [K_W-1:0]   K_RESET   = K_W'(4);
  localparam logic [IDX_W-1:0] INDEX_MAX = {IDX_W{1'b1}};

  localparam int unsigned CLOG_W = $clog2(WINDOW);
  localparam int unsigned SLOT_W = CLOG_W;
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned PROD_W = 2 * SAMPLE_BITS;
  localparam int unsigned SUM_W  = SAMPLE_BITS + CLOG_W;
  localparam int unsigned SQ_W   = 2 * SAMPLE_BITS + CLOG_W;
  localparam int unsigned VAR_W  = 2 * SUM_W;
  localparam int unsigned LHS_W  = 2 * SUM_W + CLOG_W;
  localparam int unsigned KW_W   = K_W + CLOG_W;
  localparam int unsigned RHS_W  = VAR_W + KW_W;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   restart;
    logic                   ready;
    logic [SUM_W-1:0]       sum;
    logic [SQ_W-1:0]        sq_sum;
    logic [IDX_W-1:0]       index;
  } wood_item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DEV,
    BK_SQR,
    BK_MUL,
    BK_VAR,
    BK_RHS,
    BK_DONE
  } wood_back_state_e;

endpackage

// ===== hdl/wood_front.sv =====
module wood_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [wood_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                          restart_i,
  output logic                          enq_valid_o,
  input  logic                          enq_ready_i,
  output wood_pkg::wood_item_t          enq_item_o
);

  logic [wood_pkg::SAMPLE_BITS-1:0] store_q [wood_pkg::WINDOW];
  logic [wood_pkg::SUM_W-1:0]       sum_q, sum_d, sum_eff;
  logic [wood_pkg::SQ_W-1:0]        sq_sum_q, sq_sum_d, sq_sum_eff;
  logic [wood_pkg::CNT_W-1:0]       fill_q, fill_d, fill_eff;
  logic [wood_pkg::IDX_W-1:0]       pos_q, pos_d, pos_eff;
  logic [wood_pkg::SLOT_W-1:0]      slot_q, slot_d, slot_eff;
  logic [wood_pkg::SAMPLE_BITS-1:0] x, old;
  logic [wood_pkg::PROD_W-1:0]      x_sq, old_sq;
  logic                             full, push;

  always_comb begin
    x          = sample_i[wood_pkg::SAMPLE_BITS-1:0];
    sum_eff    = restart_i ? '0 : sum_q;
    sq_sum_eff = restart_i ? '0 : sq_sum_q;
    fill_eff   = restart_i ? '0 : fill_q;
    pos_eff    = restart_i ? '0 : pos_q;
    slot_eff   = restart_i ? '0 : slot_q;
    full       = (fill_eff == wood_pkg::CNT_W'(wood_pkg::WINDOW));
    old        = store_q[slot_eff];
    x_sq       = wood_pkg::PROD_W'(x) * wood_pkg::PROD_W'(x);
    old_sq     = wood_pkg::PROD_W'(old) * wood_pkg::PROD_W'(old);

    sum_d    = sum_eff - (full ? wood_pkg::SUM_W'(old) : '0) + wood_pkg::SUM_W'(x);
    sq_sum_d = sq_sum_eff - (full ? wood_pkg::SQ_W'(old_sq) : '0) + wood_pkg::SQ_W'(x_sq);
    fill_d   = full ? fill_eff : fill_eff + 1'b1;
    slot_d   = (slot_eff == wood_pkg::SLOT_W'(wood_pkg::WINDOW - 1)) ? '0 : slot_eff + 1'b1;
    pos_d    = (pos_eff == wood_pkg::INDEX_MAX) ? pos_eff : pos_eff + 1'b1;

    push        = in_valid_i && enq_ready_i;
    in_ready_o  = enq_ready_i;
    enq_valid_o = in_valid_i;

    enq_item_o.sample  = x;
    enq_item_o.restart = restart_i;
    enq_item_o.ready   = full;
    enq_item_o.sum     = sum_eff;
    enq_item_o.sq_sum  = sq_sum_eff;
    enq_item_o.index   = pos_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      sq_sum_q <= '0;
      fill_q   <= '0;
      pos_q    <= '0;
      slot_q   <= '0;
    end else if (push) begin
      sum_q    <= sum_d;
      sq_sum_q <= sq_sum_d;
      fill_q   <= fill_d;
      pos_q    <= pos_d;
      slot_q   <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[slot_eff] <= x;
    end
  end

endmodule

// ===== hdl/wood_queue.sv =====
module wood_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 enq_valid_i,
  output logic                 enq_ready_o,
  input  wood_pkg::wood_item_t enq_item_i,
  output logic                 deq_valid_o,
  input  logic                 deq_ready_i,
  output wood_pkg::wood_item_t deq_item_o
);

  wood_pkg::wood_item_t          entry_q [wood_pkg::QUEUE_DEPTH];
  logic [wood_pkg::QPTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [wood_pkg::QCNT_W-1:0]   count_q, count_d;
  logic                          push, pop;

  always_comb begin
    enq_ready_o = (count_q != wood_pkg::QCNT_W'(wood_pkg::QUEUE_DEPTH));
    deq_valid_o = (count_q != '0);
    deq_item_o  = entry_q[rd_ptr_q];
    push        = enq_valid_i && enq_ready_o;
    pop         = deq_valid_o && deq_ready_i;
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == wood_pkg::QPTR_W'(wood_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == wood_pkg::QPTR_W'(wood_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_q + 1'b1;
    end
    count_d = count_q + wood_pkg::QCNT_W'(push) - wood_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= enq_item_i;
    end
  end

endmodule

// ===== hdl/wood_back.sv =====
module wood_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       deq_valid_i,
  output logic                       deq_ready_o,
  input  wood_pkg::wood_item_t       deq_item_i,
  input  logic [wood_pkg::K_W-1:0]   k2_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       onset_o,
  output logic                       found_o,
  output logic                       window_ready_o,
  output logic [wood_pkg::IDX_W-1:0] onset_index_o,
  output logic [wood_pkg::IDX_W-1:0] sample_index_o
);

  wood_pkg::wood_back_state_e state_q, state_d;

  wood_pkg::wood_item_t         item_q;
  logic [wood_pkg::SUM_W-1:0]   wx, dev, dev_q;
  logic [wood_pkg::VAR_W-1:0]   wq_q, sq_q, s2_q, var_q;
  logic [wood_pkg::LHS_W-1:0]   lhs_q;
  logic [wood_pkg::KW_W-1:0]    kw_q;
  logic [wood_pkg::RHS_W-1:0]   rhs_q;

  logic                         out_valid_q, out_valid_d;
  logic                         hit_q, hit_d, latch_eff, hit, breach, out_free, finish;
  logic [wood_pkg::IDX_W-1:0]   hit_pos_q, hit_pos_d, hit_pos_eff;
  logic                         onset_q, found_q, window_ready_q;
  logic [wood_pkg::IDX_W-1:0]   onset_index_q, sample_index_q;

  always_comb begin
    out_free = !out_valid_q || out_ready_i;
    state_d  = state_q;
    unique case (state_q)
      wood_pkg::BK_IDLE: if (deq_valid_i) state_d = wood_pkg::BK_DEV;
      wood_pkg::BK_DEV:  state_d = wood_pkg::BK_SQR;
      wood_pkg::BK_SQR:  state_d = wood_pkg::BK_MUL;
      wood_pkg::BK_MUL:  state_d = wood_pkg::BK_VAR;
      wood_pkg::BK_VAR:  state_d = wood_pkg::BK_RHS;
      wood_pkg::BK_RHS:  state_d = wood_pkg::BK_DONE;
      wood_pkg::BK_DONE: if (out_free) state_d = wood_pkg::BK_IDLE;
      default:           state_d = wood_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    deq_ready_o = (state_q == wood_pkg::BK_IDLE);
    finish      = (state_q == wood_pkg::BK_DONE) && out_free;

    wx  = wood_pkg::SUM_W'(wood_pkg::WINDOW) * item_q.sample;
    dev = (wx >= item_q.sum) ? wx - item_q.sum : item_q.sum - wx;

    breach      = wood_pkg::RHS_W'(lhs_q) > rhs_q;
    latch_eff   = item_q.restart ? 1'b0 : hit_q;
    hit_pos_eff = item_q.restart ? '0 : hit_pos_q;
    hit         = item_q.ready && breach && !latch_eff;
    hit_d       = latch_eff || hit;
    hit_pos_d   = hit ? item_q.index : hit_pos_eff;

    out_valid_d = finish ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wood_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      hit_pos_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (finish) begin
        hit_q     <= hit_d;
        hit_pos_q <= hit_pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (deq_ready_o && deq_valid_i) begin
      item_q <= deq_item_i;
    end
    if (state_q == wood_pkg::BK_DEV) begin
      dev_q <= dev;
      wq_q  <= wood_pkg::VAR_W'(wood_pkg::WINDOW) * wood_pkg::VAR_W'(item_q.sq_sum);
    end
    if (state_q == wood_pkg::BK_SQR) begin
      sq_q <= wood_pkg::VAR_W'(dev_q) * wood_pkg::VAR_W'(dev_q);
    end
    if (state_q == wood_pkg::BK_MUL) begin
      lhs_q <= wood_pkg::LHS_W'(wood_pkg::WINDOW - 1) * wood_pkg::LHS_W'(sq_q);
      s2_q  <= wood_pkg::VAR_W'(item_q.sum) * wood_pkg::VAR_W'(item_q.sum);
    end
    if (state_q == wood_pkg::BK_VAR) begin
      var_q <= (wq_q >= s2_q) ? wq_q - s2_q : '0;
      kw_q  <= wood_pkg::KW_W'(wood_pkg::WINDOW) * wood_pkg::KW_W'(k2_i);
    end
    if (state_q == wood_pkg::BK_RHS) begin
      rhs_q <= wood_pkg::RHS_W'(kw_q) * wood_pkg::RHS_W'(var_q);
    end
    if (finish) begin
      onset_q        <= hit;
      found_q        <= hit_d;
      window_ready_q <= item_q.ready;
      onset_index_q  <= hit_d ? hit_pos_d : '0;
      sample_index_q <= item_q.index;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign onset_o        = onset_q;
  assign found_o        = found_q;
  assign window_ready_o = window_ready_q;
  assign onset_index_o  = onset_index_q;
  assign sample_index_o = sample_index_q;

endmodule

// ===== hdl/window_outlier_onset_detect.sv =====
// An accepted input is queued, then runs through back-end states DEV, SQR, MUL, VAR,
// RHS and DONE before its result is registered. The back end takes a new item only
// when idle, and its sequencer runs the variance test one multiplier step per cycle.
// Reset clears all control state and the running statistics at once and sets the
// deviation factor to four; no clearing pass is needed.
module window_outlier_onset_detect (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [wood_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                          restart_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          onset_o,
  output logic                          found_o,
  output logic                          window_ready_o,
  output logic [wood_pkg::IDX_W-1:0]    onset_index_o,
  output logic [wood_pkg::IDX_W-1:0]    sample_index_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [wood_pkg::K_W-1:0]      deviation_factor_sq_i
);

  logic [wood_pkg::K_W-1:0] k2_q;
  logic                     enq_valid, enq_ready, deq_valid, deq_ready;
  wood_pkg::wood_item_t     enq_item, deq_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k2_q <= wood_pkg::K_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      k2_q <= deviation_factor_sq_i;
    end
  end

  wood_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .restart_i   (restart_i),
    .enq_valid_o (enq_valid),
    .enq_ready_i (enq_ready),
    .enq_item_o  (enq_item)
  );

  wood_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enq_valid_i (enq_valid),
    .enq_ready_o (enq_ready),
    .enq_item_i  (enq_item),
    .deq_valid_o (deq_valid),
    .deq_ready_i (deq_ready),
    .deq_item_o  (deq_item)
  );

  wood_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .deq_valid_i    (deq_valid),
    .deq_ready_o    (deq_ready),
    .deq_item_i     (deq_item),
    .k2_i           (k2_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .onset_o        (onset_o),
    .found_o        (found_o),
    .window_ready_o (window_ready_o),
    .onset_index_o  (onset_index_o),
    .sample_index_o (sample_index_o)
  );

endmodule
